// File: src/pldn_pkg.sv
// shared constants for the polyline densify unit
// no dependencies; imported by every module of the block
package pldn_pkg;
    localparam int FIELD_W          = 32;
    localparam int LEN_W            = 31;
    localparam int COORD_BITS_DEF   = 32;
    localparam int MAX_INSERTS_DEF  = 63;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65536);
endpackage

// File: src/pldn_sqrt.sv
// iterative floor square root, one result bit per cycle
// depends on pldn_pkg
module pldn_sqrt #(
    parameter int COORD_BITS = pldn_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [2*COORD_BITS:0]   radicand,
    output logic                    done,
    output logic [COORD_BITS:0]     root
);
    import pldn_pkg::*;

    localparam int SW  = 2 * COORD_BITS + 2;
    localparam int RTW = COORD_BITS + 1;
    localparam int RW  = COORD_BITS + 4;
    localparam int CW  = $clog2(RTW + 1);

    logic [SW-1:0]  rad_reg, rad_next;
    logic [RTW-1:0] root_reg, root_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [RW-1:0]  rem_sh, trial;

    always_comb begin
        rem_sh    = {rem_reg[RW-3:0], rad_reg[SW-1:SW-2]};
        trial     = RW'({root_reg, 2'b01});
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = {1'b0, radicand};
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CW'(RTW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RTW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[RTW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// File: src/pldn_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on pldn_pkg; quotient is known to fit COORD_BITS bits
module pldn_div #(
    parameter int COORD_BITS = pldn_pkg::COORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [COORD_BITS+pldn_pkg::LEN_W-1:0] num,
    input  logic [COORD_BITS:0]                   den,
    output logic                                  done,
    output logic [COORD_BITS-1:0]                 quo
);
    import pldn_pkg::*;

    localparam int NW = COORD_BITS + LEN_W;
    localparam int RW = COORD_BITS + 2;
    localparam int CW = $clog2(COORD_BITS + 1);

    logic [RW-1:0]         rem_reg, rem_next;
    logic [COORD_BITS-1:0] lo_reg, lo_next;
    logic [COORD_BITS-1:0] quo_reg, quo_next;
    logic [COORD_BITS:0]   den_reg, den_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RW-1:0]         rem_sh;
    logic [NW-COORD_BITS-1:0] num_hi;

    always_comb begin
        num_hi    = num[NW-1:COORD_BITS];
        rem_sh    = {rem_reg[RW-2:0], lo_reg[COORD_BITS-1]};
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // upper part is below the divisor, so it fits the remainder
            rem_next  = RW'(num_hi);
            lo_next   = num[COORD_BITS-1:0];
            quo_next  = '0;
            den_next  = den;
            cnt_next  = CW'(COORD_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            lo_next = {lo_reg[COORD_BITS-2:0], 1'b0};
            if (rem_sh >= RW'(den_reg)) begin
                rem_next = rem_sh - RW'(den_reg);
                quo_next = {quo_reg[COORD_BITS-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[COORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// File: src/polyline_densify_unit.sv
// polyline densify unit: top level with sequencer, shared multiplier and output register
// depends on pldn_pkg, pldn_sqrt, pldn_div
//
// Usage: vertices enter on the s_ channel (x, y, z, m in s_tdata, first-vertex flag
// in s_tuser). For each vertex the block emits zero or more inserted points and then
// the vertex itself on the m_ channel; m_tlast marks the vertex closing the run.
// A vertex that opens a polyline (flag set, or none seen since reset) passes
// alone. Otherwise points are inserted toward the vertex while the floor distance
// from the last emitted point exceeds max_seg_len, at most MAX_INSERTS of them;
// m_tuser bit 1 flags a vertex whose insert limit was hit.
// Each point costs one pass: the squares of both axis distances, a square root
// pass, a check, two divisions and an emit. The final vertex check takes the
// root pass only; an opening vertex goes straight to the emit. s_tready is high
// only when idle.
// Results sit in one output register; while m_tready is low the sequencer holds
// the next point until that register frees up, so nothing is lost.
// Reset (aresetn low, synchronous) clears the previous point, restores
// max_seg_len to 1.0 and empties the output register.
// cfg_we writes cfg_wdata into max_seg_len; write only while idle.
module polyline_densify_unit #(
    parameter int COORD_BITS  = pldn_pkg::COORD_BITS_DEF,
    parameter int MAX_INSERTS = pldn_pkg::MAX_INSERTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [pldn_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [4*pldn_pkg::FIELD_W-1:0] s_tdata, // pt_x, pt_y, pt_z, pt_m
    input  logic                         s_tuser,   // first_vertex
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [4*pldn_pkg::FIELD_W-1:0] m_tdata, // out_x, out_y, out_z, out_m
    output logic                         m_tlast,   // last_of_run
    output logic [1:0]                   m_tuser    // is_inserted, truncated
);
    import pldn_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int MW  = (CB > LEN_W) ? CB : LEN_W;
    localparam int DW  = (CB + 1 > LEN_W) ? CB + 1 : LEN_W;
    localparam int NW  = CB + LEN_W;
    localparam int KW  = $clog2(MAX_INSERTS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;
    localparam logic [3:0] ST_SQY   = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_ROOT  = 4'd4;
    localparam logic [3:0] ST_CHECK = 4'd5;
    localparam logic [3:0] ST_DX    = 4'd6;
    localparam logic [3:0] ST_DXW   = 4'd7;
    localparam logic [3:0] ST_DY    = 4'd8;
    localparam logic [3:0] ST_DYW   = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [CB-1:0]        vx_reg, vx_next, vy_reg, vy_next;
    logic [FIELD_W-1:0]   vz_reg, vz_next, vm_reg, vm_next;
    logic [CB-1:0]        px_reg, px_next, py_reg, py_next;
    logic                 have_prev_reg, have_prev_next;
    logic [KW-1:0]        cnt_reg, cnt_next;
    logic                 ins_reg, ins_next;
    logic                 trunc_reg, trunc_next;
    logic [2*MW-1:0]      prod_reg, prod_next;
    logic [2*CB:0]        sum_reg, sum_next;
    logic [CB:0]          dist_reg, dist_next;
    logic [CB-1:0]        qx_reg, qx_next;
    logic                 ov_reg, ov_next;
    logic [4*FIELD_W-1:0] od_reg, od_next;
    logic                 olast_reg, olast_next;
    logic [1:0]           ouser_reg, ouser_next;

    logic [LEN_W-1:0]     len_eff;
    logic [CB:0]          dx, dy;
    logic [CB-1:0]        ax, ay;
    logic [MW-1:0]        mul_a, mul_b;
    logic                 sq_start, sq_done, dv_start, dv_done;
    logic [2*CB:0]        radicand;
    logic [CB:0]          root;
    logic [CB-1:0]        quo;
    logic [CB-1:0]        step_x, step_y;
    logic [CB-1:0]        s_x, s_y;

    assign len_eff = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign s_x     = s_tdata[CB-1:0];
    assign s_y     = s_tdata[FIELD_W+CB-1:FIELD_W];

    always_comb begin
        dx = {vx_reg[CB-1], vx_reg} - {px_reg[CB-1], px_reg};
        dy = {vy_reg[CB-1], vy_reg} - {py_reg[CB-1], py_reg};
        // distance never exceeds the coordinate range, so the magnitude fits CB bits
        ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        step_x = dx[CB] ? -qx_reg : qx_reg;
        step_y = dy[CB] ? -quo : quo;
    end

    assign radicand = sum_reg + (2*CB+1)'(prod_reg[2*CB-1:0]);
    assign sq_start = (state_reg == ST_SUM);
    assign dv_start = (state_reg == ST_DX) || (state_reg == ST_DY);

    pldn_sqrt #(.COORD_BITS(CB)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (root)
    );

    pldn_div #(.COORD_BITS(CB)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     (prod_reg[NW-1:0]),
        .den     (dist_reg),
        .done    (dv_done),
        .quo     (quo)
    );

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_SQX: begin
                mul_a = MW'(ax);
                mul_b = MW'(ax);
            end
            ST_SQY, ST_SUM: begin
                mul_a = MW'(ay);
                mul_b = MW'(ay);
            end
            ST_CHECK, ST_DX, ST_DXW: begin
                mul_a = (state_reg == ST_CHECK) ? MW'(ax) : MW'(ay);
                mul_b = MW'(len_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = cfg_we ? cfg_wdata : len_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        vm_next        = vm_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        have_prev_next = have_prev_reg;
        cnt_next       = cnt_reg;
        ins_next       = ins_reg;
        trunc_next     = trunc_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        dist_next      = dist_reg;
        qx_next        = qx_reg;
        ov_next        = ov_reg && !m_tready;
        od_next        = od_reg;
        olast_next     = olast_reg;
        ouser_next     = ouser_reg;
        s_tready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    vx_next    = s_x;
                    vy_next    = s_y;
                    vz_next    = s_tdata[3*FIELD_W-1:2*FIELD_W];
                    vm_next    = s_tdata[4*FIELD_W-1:3*FIELD_W];
                    cnt_next   = '0;
                    trunc_next = 1'b0;
                    ins_next   = 1'b0;
                    state_next = (s_tuser || !have_prev_reg) ? ST_EMIT : ST_SQX;
                end
            end
            ST_SQX: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sum_next   = (2*CB+1)'(prod_reg[2*CB-1:0]);
                prod_next  = mul_a * mul_b;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sq_done) begin
                    dist_next  = root;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                prod_next = mul_a * mul_b;
                if (DW'(dist_reg) <= DW'(len_eff)) begin
                    ins_next   = 1'b0;
                    state_next = ST_EMIT;
                end else if (cnt_reg == KW'(MAX_INSERTS)) begin
                    ins_next   = 1'b0;
                    trunc_next = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DX;
                end
            end
            ST_DX: begin
                // divider has latched ax*len, so the product register moves on
                prod_next  = mul_a * mul_b;
                state_next = ST_DXW;
            end
            ST_DXW: begin
                if (dv_done) begin
                    qx_next    = quo;
                    state_next = ST_DY;
                end
            end
            ST_DY: begin
                state_next = ST_DYW;
            end
            ST_DYW: begin
                if (dv_done) begin
                    px_next    = px_reg + step_x;
                    py_next    = py_reg + step_y;
                    ins_next   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    if (ins_reg) begin
                        od_next    = {FIELD_W'(0), FIELD_W'(0),
                                      FIELD_W'($signed(py_reg)), FIELD_W'($signed(px_reg))};
                        olast_next = 1'b0;
                        ouser_next = 2'b01;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_SQX;
                    end else begin
                        od_next        = {vm_reg, vz_reg,
                                          FIELD_W'($signed(vy_reg)), FIELD_W'($signed(vx_reg))};
                        olast_next     = 1'b1;
                        ouser_next     = {trunc_reg, 1'b0};
                        px_next        = vx_reg;
                        py_next        = vy_reg;
                        have_prev_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        vz_reg    <= vz_next;
        vm_reg    <= vm_next;
        cnt_reg   <= cnt_next;
        ins_reg   <= ins_next;
        trunc_reg <= trunc_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        dist_reg  <= dist_next;
        qx_reg    <= qx_next;
        od_reg    <= od_next;
        olast_reg <= olast_next;
        ouser_reg <= ouser_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            have_prev_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            have_prev_reg <= have_prev_next;
            ov_reg        <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;
endmodule

// File: dv/tb_polyline_densify_unit.sv
// testbench for polyline_densify_unit: a local model of the densifier predicts every
// emitted point, a driver feeds vertices and a monitor checks them; depends on pldn_pkg
`timescale 1ns / 1ps

module tb_polyline_densify_unit;
    import pldn_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] m;
        logic               first;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] m;
        logic               ins;
        logic               last;
        logic               trunc;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [4*FIELD_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [4*FIELD_W-1:0] m_tdata;
    logic m_tlast;
    logic [1:0] m_tuser;

    polyline_densify_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    vertex_t pending_vertices[$];
    point_t  expected_points[$];
    int      send_idle_pct = 9;
    int      recv_idle_pct = 69;
    int      errors = 0;
    int      quiet_cycles = 0;
    logic    finishing = 1'b0;
    logic    s_taken = 1'b0;

    // densifier state
    logic [30:0]        seg_len = 31'd65536;
    logic signed [63:0] last_x = 0;
    logic signed [63:0] last_y = 0;
    logic               have_last = 1'b0;

    function automatic logic [63:0] floor_root(logic [64:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [129:0] sq;
        r = 0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = c * c;
            if (sq <= {65'd0, v}) r = c;
        end
        return r;
    endfunction

    task automatic predict_points(input vertex_t v);
        logic signed [63:0] vx, vy, dx, dy;
        logic [63:0] ax, ay, len, seg_root, qx, qy;
        logic [64:0] sumsq, bound;
        int count;
        logic trunc;
        point_t p;
        vx = v.x;
        vy = v.y;
        len = (seg_len == 0) ? 64'd1 : {33'd0, seg_len};
        bound = (len + 1) * (len + 1);
        count = 0;
        trunc = 1'b0;
        if (!v.first && have_last) begin
            forever begin
                dx = vx - last_x;
                dy = vy - last_y;
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                sumsq = {1'b0, ax * ax} + {1'b0, ay * ay};
                if (sumsq < bound) break;
                if (count >= 63) begin
                    trunc = 1'b1;
                    break;
                end
                seg_root = floor_root(sumsq);
                qx = (ax * len) / seg_root;
                qy = (ay * len) / seg_root;
                last_x = dx < 0 ? last_x - qx : last_x + qx;
                last_y = dy < 0 ? last_y - qy : last_y + qy;
                p = '{last_x[31:0], last_y[31:0], 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b0};
                expected_points.push_back(p);
                count++;
            end
        end
        p = '{v.x, v.y, v.z, v.m, 1'b0, 1'b1, trunc};
        expected_points.push_back(p);
        last_x = vx;
        last_y = vy;
        have_last = 1'b1;
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                vertex_t v;
                v = pending_vertices.pop_front();
                s_tdata <= {v.m, v.z, v.y, v.x};
                s_tuser <= v.first;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // input transfer seen at the last rising edge
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
    end

    // monitor and prediction at the accepting edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                vertex_t v;
                v = '{s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96],
                      s_tuser};
                predict_points(v);
            end
            if (m_tvalid && m_tready) begin
                point_t e;
                if (expected_points.size() == 0) begin
                    $error("unexpected output transfer x=%h y=%h", m_tdata[31:0],
                           m_tdata[63:32]);
                    errors++;
                end else begin
                    e = expected_points.pop_front();
                    if (m_tdata[31:0] !== e.x) begin
                        $error("out_x expected %h actual %h", e.x, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== e.y) begin
                        $error("out_y expected %h actual %h", e.y, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tdata[95:64] !== e.z) begin
                        $error("out_z expected %h actual %h", e.z, m_tdata[95:64]);
                        errors++;
                    end
                    if (m_tdata[127:96] !== e.m) begin
                        $error("out_m expected %h actual %h", e.m, m_tdata[127:96]);
                        errors++;
                    end
                    if (m_tuser[0] !== e.ins) begin
                        $error("is_inserted expected %b actual %b", e.ins, m_tuser[0]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_of_run expected %b actual %b", e.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser[1] !== e.trunc) begin
                        $error("truncated expected %b actual %b", e.trunc, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= LIMIT_CYCLES) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_vertex(input logic [31:0] x, y, z, m, input logic first);
        vertex_t v;
        v = '{x, y, z, m, first};
        pending_vertices.push_back(v);
    endtask

    task automatic drain();
        wait (pending_vertices.size() == 0 && !s_tvalid && expected_points.size() == 0);
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_seg_len(input logic [30:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        seg_len = val;
    endtask

    // random coordinate: mostly near the last point so runs stay short
    function automatic logic [31:0] near_coord(logic [31:0] base, int span);
        return base + $signed($urandom_range(2 * span) - span);
    endfunction

    task automatic random_phase(input int n, input logic [30:0] len);
        logic [31:0] x, y;
        int span;
        x = $urandom;
        y = $urandom;
        for (int i = 0; i < n; i++) begin
            int kind;
            kind = $urandom_range(99);
            // span scales with the segment length so most vertices take a few inserts
            span = (len > 31'd20000000) ? 32'h7fffffff / 2 : len * $urandom_range(1, 12);
            if (kind < 8) begin
                x = $urandom;
                y = $urandom;
                add_vertex(x, y, $urandom, $urandom, 1'($urandom_range(1)));
            end else begin
                x = near_coord(x, span);
                y = near_coord(y, span);
                add_vertex(x, y, $urandom, $urandom, kind < 14);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: opening vertex, extremes, exact length, truncation, both axes
        add_vertex(32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h8765_4321, 1'b0);
        add_vertex(32'h0003_0000, 32'h0004_0000, 32'hffff_ffff, 32'h0, 1'b0);
        add_vertex(32'h0004_0000, 32'h0004_0000, 32'h1, 32'h2, 1'b0);
        add_vertex(32'h0004_0000, 32'h0004_ffff, 32'h0, 32'h0, 1'b0);
        add_vertex(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1);
        add_vertex(32'hffc0_0000, 32'h0, 32'h0, 32'h0, 1'b0);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
        add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
        add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
        drain();

        set_seg_len(31'h7fff_ffff);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h5, 32'h6, 1'b0);
        add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7, 32'h8, 1'b0);
        add_vertex(32'h8000_0000, 32'h0, 32'h7, 32'h8, 1'b0);
        drain();

        set_seg_len(31'd0);
        add_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        add_vertex(32'h0000_0020, 32'hffff_ffe0, 32'h0, 32'h0, 1'b0);
        add_vertex(32'h0000_0021, 32'hffff_ffe0, 32'h0, 32'h0, 1'b0);
        drain();

        set_seg_len(31'd1);
        add_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_vertex(32'h0000_0100, 32'h0, 32'h0, 32'h0, 1'b0);
        drain();

        set_seg_len(31'd65536);
        random_phase(90, 31'd65536);
        drain();
        send_idle_pct = 69;
        recv_idle_pct = 9;
        set_seg_len(31'd300);
        random_phase(90, 31'd300);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_seg_len(31'h7fff_ffff);
        random_phase(30, 31'h7fff_ffff);
        drain();
        set_seg_len(31'd1000000);
        random_phase(60, 31'd1000000);
        drain();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
